[hw/rtl/gmt_pkg.sv]
// gmt_pkg: shared sizes, codes and types of the grid mesh triangulator
// used by every module under hw/rtl; no dependencies
package gmt_pkg;

    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_WIDTH  = 2048;

    localparam int NUM_W  = 23;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int HSZ_W  = ROW_W + 1;
    localparam int WSZ_W  = COL_W + 1;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        KIND_VERTEX = 1'b0,
        KIND_FACE   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

    // pixel after numbering, together with its buffer read data
    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] prev;
        logic             col_ok;
        logic             up_ok;
        logic [NUM_W-1:0] left;
        logic [NUM_W-1:0] up;
    } t_cell;

endpackage

[hw/rtl/gmt_regs.sv]
// gmt_regs: configuration register file behind the apb-style port
// depends on gmt_pkg
module gmt_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gmt_pkg::ADDR_W-1:0]   paddr,
    input  logic [gmt_pkg::DATA_W-1:0]   pwdata,
    output logic [gmt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output gmt_pkg::t_cfg                o_cfg
);

    gmt_pkg::t_cfg    r_cfg;
    gmt_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = gmt_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= gmt_pkg::CFG_W'(640);
            r_cfg.height <= gmt_pkg::CFG_W'(480);
        end else if (w_wr) begin
            case (w_idx)
                gmt_pkg::REG_GRID_WIDTH:  r_cfg.width  <= pwdata[gmt_pkg::CFG_W-1:0];
                gmt_pkg::REG_GRID_HEIGHT: r_cfg.height <= pwdata[gmt_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            gmt_pkg::REG_GRID_WIDTH:
                prdata = gmt_pkg::DATA_W'(r_cfg.width);
            gmt_pkg::REG_GRID_HEIGHT:
                prdata = gmt_pkg::DATA_W'(r_cfg.height);
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/gmt_numbering.sv]
// gmt_numbering: grid position and vertex counters, one-column number buffer
// depends on gmt_pkg; feeds gmt_emitter
module gmt_numbering (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gmt_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic          i_pixel_valid,
    output logic          o_stall,
    input  logic          i_advance,
    output gmt_pkg::t_cell o_cell
);

    logic [gmt_pkg::NUM_W-1:0] mem [gmt_pkg::MAX_HEIGHT];

    logic [gmt_pkg::NUM_W-1:0] r_count, n_count;
    logic [gmt_pkg::NUM_W-1:0] r_prev, n_prev;
    logic [gmt_pkg::ROW_W-1:0] r_row, n_row;
    logic [gmt_pkg::COL_W-1:0] r_col, n_col;

    logic                      r_s1_valid;
    logic [gmt_pkg::NUM_W-1:0] r_s1_num;
    logic [gmt_pkg::NUM_W-1:0] r_s1_prev;
    logic                      r_s1_col_ok;
    logic                      r_s1_up_ok;
    logic [gmt_pkg::NUM_W-1:0] r_rd_left;
    logic [gmt_pkg::NUM_W-1:0] r_rd_up;

    logic [gmt_pkg::HSZ_W-1:0] w_h;
    logic [gmt_pkg::WSZ_W-1:0] w_w;
    logic [gmt_pkg::HSZ_W-1:0] w_row_inc;
    logic [gmt_pkg::WSZ_W-1:0] w_col_inc;
    logic [gmt_pkg::NUM_W-1:0] w_num;
    logic [gmt_pkg::NUM_W-1:0] w_count_inc;
    logic [gmt_pkg::ROW_W-1:0] w_up_addr;
    logic                      w_accept;

    // sizes: zero acts as one, large values saturate
    always_comb begin
        if (i_cfg.height == '0) begin
            w_h = gmt_pkg::HSZ_W'(1);
        end else if (32'(i_cfg.height) > gmt_pkg::MAX_HEIGHT) begin
            w_h = gmt_pkg::HSZ_W'(gmt_pkg::MAX_HEIGHT);
        end else begin
            w_h = gmt_pkg::HSZ_W'(i_cfg.height);
        end
        if (i_cfg.width == '0) begin
            w_w = gmt_pkg::WSZ_W'(1);
        end else if (32'(i_cfg.width) > gmt_pkg::MAX_WIDTH) begin
            w_w = gmt_pkg::WSZ_W'(gmt_pkg::MAX_WIDTH);
        end else begin
            w_w = gmt_pkg::WSZ_W'(i_cfg.width);
        end
    end

    assign o_stall  = r_s1_valid & ~i_advance;
    assign w_accept = i_valid & ~o_stall;

    assign w_num       = i_pixel_valid ? r_count : '0;
    assign w_row_inc   = {1'b0, r_row} + gmt_pkg::HSZ_W'(1);
    assign w_col_inc   = {1'b0, r_col} + gmt_pkg::WSZ_W'(1);
    assign w_count_inc = r_count + gmt_pkg::NUM_W'(1);
    assign w_up_addr   = w_row_inc[gmt_pkg::ROW_W-1:0];

    always_comb begin
        n_count = r_count;
        n_prev  = w_num;
        n_row   = w_row_inc[gmt_pkg::ROW_W-1:0];
        n_col   = r_col;
        if (i_pixel_valid) begin
            n_count = (w_count_inc == '0) ? gmt_pkg::NUM_W'(1) : w_count_inc;
        end
        if (w_row_inc >= w_h) begin
            n_row  = '0;
            n_prev = '0;
            n_col  = w_col_inc[gmt_pkg::COL_W-1:0];
            if (w_col_inc >= w_w) begin
                n_col   = '0;
                n_count = gmt_pkg::NUM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= gmt_pkg::NUM_W'(1);
            r_prev     <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_prev  <= n_prev;
                r_row   <= n_row;
                r_col   <= n_col;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // read before write on the same row: left sees the previous column
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_row]  <= w_num;
            r_rd_left   <= mem[r_row];
            r_rd_up     <= mem[w_up_addr];
            r_s1_num    <= w_num;
            r_s1_prev   <= (r_row != '0) ? r_prev : '0;
            r_s1_col_ok <= (r_col != '0);
            r_s1_up_ok  <= (w_row_inc < w_h);
        end
    end

    always_comb begin
        o_cell.valid  = r_s1_valid;
        o_cell.num    = r_s1_num;
        o_cell.prev   = r_s1_prev;
        o_cell.col_ok = r_s1_col_ok;
        o_cell.up_ok  = r_s1_up_ok;
        o_cell.left   = r_rd_left;
        o_cell.up     = r_rd_up;
    end

endmodule

[hw/rtl/gmt_emitter.sv]
// gmt_emitter: face tests and serialising of up to three records per pixel
// depends on gmt_pkg; takes cells from gmt_numbering
module gmt_emitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gmt_pkg::t_cell             i_cell,
    output logic                       o_advance,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_record_kind,
    output logic [gmt_pkg::NUM_W-1:0]  o_first_index,
    output logic [gmt_pkg::NUM_W-1:0]  o_second_index,
    output logic [gmt_pkg::NUM_W-1:0]  o_third_index,
    output logic                       o_last_of_run
);

    // pending bits: vertex, face a, face b
    logic [2:0]                r_pend, n_pend;
    logic [gmt_pkg::NUM_W-1:0] r_num, r_left, r_up, r_prev;

    logic                      r_out_valid;
    logic                      r_out_kind;
    logic [gmt_pkg::NUM_W-1:0] r_out_a, r_out_b, r_out_c;
    logic                      r_out_last;

    logic                      w_out_load;
    logic                      w_emit;
    logic [2:0]                w_rest;
    logic                      w_kind;
    logic [gmt_pkg::NUM_W-1:0] w_a, w_b, w_c;
    logic [2:0]                w_new_pend;
    logic                      w_vtx, w_fa, w_fb;
    logic [gmt_pkg::NUM_W-1:0] w_up;

    assign w_out_load = ~r_out_valid | ~i_stall;
    assign w_emit     = (r_pend != '0) & w_out_load;

    always_comb begin
        w_rest = r_pend;
        w_kind = gmt_pkg::KIND_VERTEX;
        w_a    = r_num;
        w_b    = '0;
        w_c    = '0;
        if (r_pend[0]) begin
            w_rest[0] = 1'b0;
        end else if (r_pend[1]) begin
            w_rest[1] = 1'b0;
            w_kind    = gmt_pkg::KIND_FACE;
            w_a       = r_left;
            w_b       = r_num;
            w_c       = r_up;
        end else begin
            w_rest[2] = 1'b0;
            w_kind    = gmt_pkg::KIND_FACE;
            w_a       = r_left;
            w_b       = r_prev;
            w_c       = r_num;
        end
    end

    assign o_advance = i_cell.valid & ((r_pend == '0) | (w_emit & (w_rest == '0)));

    assign w_up  = i_cell.up_ok ? i_cell.up : '0;
    assign w_vtx = (i_cell.num != '0);
    assign w_fa  = w_vtx & i_cell.col_ok & (i_cell.left != '0) & (w_up != '0);
    assign w_fb  = w_vtx & i_cell.col_ok & (i_cell.left != '0) & (i_cell.prev != '0);
    assign w_new_pend = {w_fb, w_fa, w_vtx};

    always_comb begin
        n_pend = r_pend;
        if (w_emit) begin
            n_pend = w_rest;
        end
        if (o_advance) begin
            n_pend = w_new_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_out_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_num  <= i_cell.num;
            r_left <= i_cell.left;
            r_up   <= w_up;
            r_prev <= i_cell.prev;
        end
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_a    <= w_a;
            r_out_b    <= w_b;
            r_out_c    <= w_c;
            r_out_last <= (w_rest == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_record_kind  = r_out_kind;
    assign o_first_index  = r_out_a;
    assign o_second_index = r_out_b;
    assign o_third_index  = r_out_c;
    assign o_last_of_run  = r_out_last;

endmodule

[hw/rtl/grid_mesh_triangulator_unit.sv]
// grid_mesh_triangulator_unit: top level of the grid mesh triangulator
// depends on gmt_pkg, gmt_regs, gmt_numbering, gmt_emitter
//
// Pixels arrive column by column, one validity flag per request, and the
// unit numbers valid pixels from 1 and gives a vertex record for each, then
// up to two triangle records for the cell closed against the previous
// column. Vertex numbers of the previous column live in a 2048-entry buffer
// read at two rows and written at one row in the cycle a request is taken.
// One request waits after the buffer read while the face stage drains the
// records of the one before it. The result channel moves one record per
// cycle while the receiver does not stall, so a pixel holds the face stage
// until its records are out and input is stalled meanwhile; sustained
// throughput is set by the record count and receiver stalls, and pixels
// with at most one record each flow at one per cycle when unstalled. The
// first record of a request reaches the outputs through the buffer read,
// the face test and the output register.
module grid_mesh_triangulator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gmt_pkg::ADDR_W-1:0]  paddr,
    input  logic [gmt_pkg::DATA_W-1:0]  pwdata,
    output logic [gmt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_pixel_valid,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_record_kind,
    output logic [gmt_pkg::NUM_W-1:0]   o_first_index,
    output logic [gmt_pkg::NUM_W-1:0]   o_second_index,
    output logic [gmt_pkg::NUM_W-1:0]   o_third_index,
    output logic                        o_last_of_run
);

    gmt_pkg::t_cfg  w_cfg;
    gmt_pkg::t_cell w_cell;
    logic           w_advance;

    gmt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gmt_numbering u_numbering (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .i_pixel_valid (i_pixel_valid),
        .o_stall       (o_stall),
        .i_advance     (w_advance),
        .o_cell        (w_cell)
    );

    gmt_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cell         (w_cell),
        .o_advance      (w_advance),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_kind  (o_record_kind),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_third_index  (o_third_index),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

[test/grid_mesh_triangulator_unit_tb.sv]
// testbench for grid_mesh_triangulator_unit: vertex and face records predicted per pixel request
// depends on gmt_pkg and the grid_mesh_triangulator_unit rtl; self-checking, no external files
`timescale 1ns / 1ps

module grid_mesh_triangulator_unit_tb;

    typedef struct packed {
        gmt_pkg::t_kind            kind;
        logic [gmt_pkg::NUM_W-1:0] first_idx;
        logic [gmt_pkg::NUM_W-1:0] second_idx;
        logic [gmt_pkg::NUM_W-1:0] third_idx;
        logic                      last;
    } t_mesh_rec;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [gmt_pkg::ADDR_W-1:0]   paddr;
    logic [gmt_pkg::DATA_W-1:0]   pwdata;
    logic [gmt_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_pixel_valid;
    logic                         o_valid;
    logic                         i_stall;
    logic                         o_record_kind;
    logic [gmt_pkg::NUM_W-1:0]    o_first_index;
    logic [gmt_pkg::NUM_W-1:0]    o_second_index;
    logic [gmt_pkg::NUM_W-1:0]    o_third_index;
    logic                         o_last_of_run;

    t_mesh_rec                    pending_records[$];
    t_mesh_rec                    got_rec;
    int                           mismatch_count = 0;
    bit                           idle_on = 1'b1;
    int                           hold_cycles = 0;

    logic [gmt_pkg::CFG_W-1:0]    cfg_width;
    logic [gmt_pkg::CFG_W-1:0]    cfg_height;
    logic [gmt_pkg::NUM_W-1:0]    column_numbers [gmt_pkg::MAX_HEIGHT];
    logic [gmt_pkg::NUM_W-1:0]    prev_number;
    logic [gmt_pkg::NUM_W-1:0]    next_vertex;
    int unsigned                  row_pos;
    int unsigned                  col_pos;

    grid_mesh_triangulator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_valid  (i_pixel_valid),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_kind  (o_record_kind),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_third_index  (o_third_index),
        .o_last_of_run  (o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned eff_size(input logic [gmt_pkg::CFG_W-1:0] v,
                                             input int unsigned top);
        if (v == '0) return 1;
        if (v > top) return top;
        return 32'(v);
    endfunction

    function automatic void compare_field(input string name, input int unsigned exp_val,
                                          input int unsigned act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // numbers one pixel and queues the records it causes
    function automatic void predict_mesh_records(input bit pix);
        t_mesh_rec                 recs[$];
        int unsigned               w;
        int unsigned               h;
        int unsigned               j;
        logic [gmt_pkg::NUM_W-1:0] num;
        logic [gmt_pkg::NUM_W-1:0] left;
        logic [gmt_pkg::NUM_W-1:0] up;
        logic [gmt_pkg::NUM_W-1:0] above;
        w = eff_size(cfg_width, gmt_pkg::MAX_WIDTH);
        h = eff_size(cfg_height, gmt_pkg::MAX_HEIGHT);
        j = (row_pos >= gmt_pkg::MAX_HEIGHT) ? gmt_pkg::MAX_HEIGHT - 1 : row_pos;
        num = '0;
        if (pix) begin
            num = next_vertex;
            next_vertex = next_vertex + 1'b1;
            if (next_vertex == '0) next_vertex = gmt_pkg::NUM_W'(1);
            recs.push_back('{gmt_pkg::KIND_VERTEX, num, '0, '0, 1'b0});
        end
        if (col_pos >= 1 && num != '0) begin
            left  = column_numbers[gmt_pkg::ROW_W'(j)];
            up    = (j + 1 < h) ? column_numbers[gmt_pkg::ROW_W'(j + 1)] : '0;
            above = (j > 0) ? prev_number : '0;
            if (left != '0 && up != '0) begin
                recs.push_back('{gmt_pkg::KIND_FACE, left, num, up, 1'b0});
            end
            if (left != '0 && above != '0) begin
                recs.push_back('{gmt_pkg::KIND_FACE, left, above, num, 1'b0});
            end
        end
        if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
        foreach (recs[k]) pending_records.push_back(recs[k]);
        column_numbers[gmt_pkg::ROW_W'(j)] = num;
        prev_number = num;
        row_pos = j + 1;
        if (row_pos >= h) begin
            row_pos = 0;
            prev_number = '0;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                next_vertex = gmt_pkg::NUM_W'(1);
            end
        end
    endfunction

    task automatic apb_access(input bit wr, input gmt_pkg::t_reg_idx idx,
                              input logic [gmt_pkg::DATA_W-1:0] wdata,
                              output logic [gmt_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input gmt_pkg::t_reg_idx idx);
        logic [gmt_pkg::DATA_W-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (idx == gmt_pkg::REG_GRID_WIDTH)
            compare_field("grid_width", 32'(cfg_width), 32'(rdata[gmt_pkg::CFG_W-1:0]));
        else
            compare_field("grid_height", 32'(cfg_height), 32'(rdata[gmt_pkg::CFG_W-1:0]));
    endtask

    task automatic write_reg(input gmt_pkg::t_reg_idx idx, input int unsigned val);
        logic [gmt_pkg::DATA_W-1:0] rdata;
        apb_access(1'b1, idx, gmt_pkg::DATA_W'(val), rdata);
        if (idx == gmt_pkg::REG_GRID_WIDTH)
            cfg_width = gmt_pkg::CFG_W'(val);
        else
            cfg_height = gmt_pkg::CFG_W'(val);
        check_reg(idx);
    endtask

    task automatic send_pixel(input bit pix);
        i_valid       <= 1'b1;
        i_pixel_valid <= pix;
        do @(posedge i_clk); while (o_stall);
        predict_mesh_records(pix);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // also covers pixels that leave no record behind
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic test_defaults();
        check_reg(gmt_pkg::REG_GRID_WIDTH);
        check_reg(gmt_pkg::REG_GRID_HEIGHT);
    endtask

    task automatic test_small_grid();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 3);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 3);
        for (int p = 0; p < 9; p++) send_pixel(p != 4);
        wait_idle();
    endtask

    task automatic test_zero_size();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 0);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        wait_idle();
    endtask

    task automatic test_mid_frame_resize();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 4);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 4);
        repeat (6) send_pixel(1'b1);
        wait_idle();
        // row already past the new height: column closes on the next request
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 2);
        send_pixel(1'b1);
        wait_idle();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 2);
        repeat (6) send_pixel(1'b1);
        wait_idle();
    endtask

    task automatic test_height_clamp();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 2);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 2049);
        repeat (6) send_pixel(1'b1);
        wait_idle();
        // shrinking the height closes the long column on the next request
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 2);
        repeat (3) send_pixel(1'b1);
        wait_idle();
    endtask

    task automatic test_width_clamp();
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 2);
        write_reg(gmt_pkg::REG_GRID_WIDTH, 2049);
        repeat (8) send_pixel(1'b1);
        wait_idle();
        // column already past the new width: frame closes after this column
        write_reg(gmt_pkg::REG_GRID_WIDTH, 2);
        repeat (2) send_pixel(1'b1);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(gmt_pkg::REG_GRID_WIDTH, 4);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 3);
        idle_on = 1'b0;
        hold_cycles = 400;
        repeat (48) send_pixel(1'b1);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int          sent;
        int unsigned w;
        int unsigned h;
        int unsigned density;
        int unsigned frames;
        sent = 0;
        while (sent < 200) begin
            w = $urandom_range(0, 6);
            h = $urandom_range(0, 8);
            if ($urandom_range(0, 4) == 0) begin
                w = 2;
                h = $urandom_range(9, 24);
            end
            case ($urandom_range(0, 3))
                0:       density = 40;
                1:       density = 75;
                default: density = 95;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            write_reg(gmt_pkg::REG_GRID_WIDTH, w);
            write_reg(gmt_pkg::REG_GRID_HEIGHT, h);
            frames = $urandom_range(1, 3);
            repeat (frames * eff_size(cfg_width, gmt_pkg::MAX_WIDTH)
                    * eff_size(cfg_height, gmt_pkg::MAX_HEIGHT))
            begin
                send_pixel($urandom_range(0, 99) < density);
                sent++;
            end
            wait_idle();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_reg(gmt_pkg::REG_GRID_WIDTH, 5);
        write_reg(gmt_pkg::REG_GRID_HEIGHT, 4);
        repeat (60) send_pixel($urandom_range(0, 99) < 85);
        wait_idle();
    endtask

    // receiver side: random stall bursts, or one long hold when asked
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                while (hold_cycles > 0) begin
                    @(posedge i_clk);
                    hold_cycles--;
                end
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_records.size() == 0) begin
                $error("record with nothing expected: kind %0d first %0d second %0d third %0d",
                       o_record_kind, o_first_index, o_second_index, o_third_index);
                mismatch_count++;
            end else begin
                got_rec = pending_records.pop_front();
                compare_field("record_kind", 32'(got_rec.kind), 32'(o_record_kind));
                compare_field("first_index", 32'(got_rec.first_idx), 32'(o_first_index));
                compare_field("second_index", 32'(got_rec.second_idx), 32'(o_second_index));
                compare_field("third_index", 32'(got_rec.third_idx), 32'(o_third_index));
                compare_field("last_of_run", 32'(got_rec.last), 32'(o_last_of_run));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_pixel_valid = 1'b0;
        cfg_width     = gmt_pkg::CFG_W'(640);
        cfg_height    = gmt_pkg::CFG_W'(480);
        prev_number   = '0;
        next_vertex   = gmt_pkg::NUM_W'(1);
        row_pos       = 0;
        col_pos       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_small_grid();
        test_zero_size();
        test_mid_frame_resize();
        test_height_clamp();
        test_width_clamp();
        test_output_backpressure();
        test_random_frames();
        test_back_to_back();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[grid_mesh_triangulator_unit.f]
hw/rtl/gmt_pkg.sv
hw/rtl/gmt_regs.sv
hw/rtl/gmt_numbering.sv
hw/rtl/gmt_emitter.sv
hw/rtl/grid_mesh_triangulator_unit.sv
test/grid_mesh_triangulator_unit_tb.sv
